>>> rtl/email_address_validator_core_defines.svh
// ----------------------------------------------------------------------------
// Email address validator: assertion macros
// Shared concurrent-check wrappers, clocked on clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef EMAIL_ADDRESS_VALIDATOR_CORE_DEFINES_SVH
`define EMAIL_ADDRESS_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication check.
`define EAV_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eav check failed");

// Next-cycle implication check.
`define EAV_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eav check failed");

`endif

>>> rtl/eav_pkg.sv
// ----------------------------------------------------------------------------
// Email address validator package
// Types, register defaults, character codes and character class functions.
// ----------------------------------------------------------------------------
`default_nettype none

package eav_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LABEL_W = 7;

   typedef enum logic [2:0] {
      PH_ATOM_START  = 3'd0,
      PH_ATOM        = 3'd1,
      PH_LABEL_START = 3'd2,
      PH_LABEL       = 3'd3,
      PH_FAILED      = 3'd4
   } eav_phase_type;

   typedef enum logic [1:0] {
      CSR_MAX_TOTAL = 2'd0,
      CSR_MIN_TOTAL = 2'd1,
      CSR_MAX_LOCAL = 2'd2,
      CSR_MAX_LABEL = 2'd3
   } eav_csr_index_type;

   localparam logic [BYTE_W-1:0]  MAX_TOTAL_RESET = 8'd254;
   localparam logic [BYTE_W-1:0]  MIN_TOTAL_RESET = 8'd3;
   localparam logic [LABEL_W-1:0] MAX_LOCAL_RESET = 7'd64;
   localparam logic [LABEL_W-1:0] MAX_LABEL_RESET = 7'd63;

   localparam logic [BYTE_W-1:0]  CHAR_AT   = 8'h40;
   localparam logic [BYTE_W-1:0]  CHAR_DOT  = 8'h2E;
   localparam logic [BYTE_W-1:0]  CHAR_DASH = 8'h2D;

   localparam logic [BYTE_W-1:0]  BYTE_MAX  = '1;
   localparam logic [LABEL_W-1:0] LABEL_MAX = '1;

   typedef struct packed {
      logic [BYTE_W-1:0]  max_total_length;
      logic [BYTE_W-1:0]  min_total_length;
      logic [LABEL_W-1:0] max_local_length;
      logic [LABEL_W-1:0] max_label_length;
   } eav_cfg_type;

   typedef struct packed {
      eav_phase_type      phase;
      logic [BYTE_W-1:0]  total_count;
      logic [BYTE_W-1:0]  local_count;
      logic [LABEL_W-1:0] label_count;
      logic [BYTE_W-1:0]  at_index;
   } eav_state_type;

   typedef struct packed {
      logic              address_ok;
      logic [BYTE_W-1:0] split_position;
   } eav_result_type;

   localparam eav_state_type STATE_CLEAR = '{
      phase:       PH_ATOM_START,
      total_count: '0,
      local_count: '0,
      label_count: '0,
      at_index:    '0
   };

   function automatic logic is_alnum_lower(input logic [BYTE_W-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h30) && (c <= 8'h39));
   endfunction

   function automatic logic is_local_char(input logic [BYTE_W-1:0] c);
      logic special;
      special = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
                (c == 8'h26) || (c == 8'h2A) || (c == 8'h2B) || (c == 8'h2F) ||
                (c == 8'h3D) || (c == 8'h3F) || (c == 8'h5E) || (c == 8'h5F) ||
                (c == 8'h60) || (c == 8'h7B) || (c == 8'h7C) || (c == 8'h7D) ||
                (c == 8'h7E) || (c == CHAR_DASH);
      return special || is_alnum_lower(c);
   endfunction

endpackage

`default_nettype wire

>>> rtl/eav_step.sv
// ----------------------------------------------------------------------------
// Email address validator: parse step
// Next parser state and verdict for one byte, pure combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module eav_step (
   input  eav_pkg::eav_state_type  state,
   input  eav_pkg::eav_cfg_type    cfg,
   input  logic [7:0]              char_byte,
   input  logic                    is_final,
   output eav_pkg::eav_state_type  state_next,
   output eav_pkg::eav_result_type result
);
   import eav_pkg::*;

   logic                 local_ch;
   logic                 alnum_ch;
   logic                 local_fits;
   logic                 label_fits;
   eav_phase_type        phase_step;
   logic [BYTE_W-1:0]    total_step;
   logic [BYTE_W-1:0]    local_step;
   logic [LABEL_W-1:0]   label_step;
   logic [BYTE_W-1:0]    at_step;
   logic                 ok;

   assign local_ch   = is_local_char(char_byte);
   assign alnum_ch   = is_alnum_lower(char_byte);
   assign local_fits = state.local_count <= {1'b0, cfg.max_local_length};
   assign label_fits = state.label_count <= cfg.max_label_length;

   // next phase
   always_comb begin
      phase_step = PH_FAILED;
      unique case (state.phase)
         PH_ATOM_START: begin
            phase_step = local_ch ? PH_ATOM : PH_FAILED;
         end
         PH_ATOM: begin
            priority if (local_ch)                           phase_step = PH_ATOM;
            else if (char_byte == CHAR_DOT)                  phase_step = PH_ATOM_START;
            else if (char_byte == CHAR_AT && local_fits)     phase_step = PH_LABEL_START;
            else                                             phase_step = PH_FAILED;
         end
         PH_LABEL_START: begin
            phase_step = alnum_ch ? PH_LABEL : PH_FAILED;
         end
         PH_LABEL: begin
            priority if (alnum_ch) phase_step = PH_LABEL;
            else if ((char_byte == CHAR_DASH || char_byte == CHAR_DOT) && label_fits)
               phase_step = PH_LABEL_START;
            else
               phase_step = PH_FAILED;
         end
         default: begin
            phase_step = PH_FAILED;
         end
      endcase
   end

   // counters
   always_comb begin
      total_step = (state.total_count == BYTE_MAX) ? state.total_count
                                                   : state.total_count + 8'd1;
      local_step = state.local_count;
      label_step = state.label_count;
      at_step    = state.at_index;
      unique case (state.phase)
         PH_ATOM_START: begin
            if (local_ch && state.local_count != BYTE_MAX) local_step = state.local_count + 8'd1;
         end
         PH_ATOM: begin
            if ((local_ch || char_byte == CHAR_DOT) && state.local_count != BYTE_MAX) begin
               local_step = state.local_count + 8'd1;
            end else if (!local_ch && char_byte != CHAR_DOT && char_byte == CHAR_AT &&
                         local_fits) begin
               at_step    = state.local_count;
               label_step = '0;
            end
         end
         PH_LABEL_START: begin
            if (alnum_ch) label_step = 7'd1;
         end
         PH_LABEL: begin
            if (alnum_ch) begin
               if (state.label_count != LABEL_MAX) label_step = state.label_count + 7'd1;
            end else if ((char_byte == CHAR_DASH || char_byte == CHAR_DOT) && label_fits) begin
               label_step = '0;
            end
         end
         default: begin
            label_step = state.label_count;
         end
      endcase
   end

   // verdict, and clear the address state after the final byte
   always_comb begin
      ok = (phase_step == PH_LABEL) &&
           (label_step != '0) && (label_step <= cfg.max_label_length) &&
           (total_step >= cfg.min_total_length) && (total_step <= cfg.max_total_length) &&
           (at_step != '0);
      result.address_ok     = ok;
      result.split_position = ok ? at_step : '0;
      if (is_final) begin
         state_next = STATE_CLEAR;
      end else begin
         state_next.phase       = phase_step;
         state_next.total_count = total_step;
         state_next.local_count = local_step;
         state_next.label_count = label_step;
         state_next.at_index    = at_step;
      end
   end

endmodule

`default_nettype wire

>>> rtl/email_address_validator_core.sv
// ----------------------------------------------------------------------------
// Email address validator core
// Byte-serial address syntax check with one verdict per address.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | char_byte, is_final
//  rsp     | out       | rsp_valid/rsp_stall | address_ok, split_position
//  csr     | in        | csr_valid/csr_ready | index (2b), data (8b)
//
//  One byte per cycle while req_stall is low; a byte is registered on being
//  taken, then parsed; a verdict is registered in rsp_ff to drive rsp_valid.
//  The parse step between input register and result register sets the rate.
//  Reset (synchronous) restores register defaults and the parser start state.
//  A stalled verdict holds back the next final byte and the bytes behind it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "email_address_validator_core_defines.svh"

module email_address_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_address_ok,
   output logic [7:0] rsp_split_position,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   import eav_pkg::*;

   eav_cfg_type       cfg_ff;
   eav_state_type     state_ff;
   eav_state_type     state_in;
   eav_result_type    result_in;
   eav_result_type    rsp_ff;
   logic              rsp_vld_ff;
   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_fin_ff;
   logic              advance;
   eav_csr_index_type csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = eav_csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_total_length <= MAX_TOTAL_RESET;
         cfg_ff.min_total_length <= MIN_TOTAL_RESET;
         cfg_ff.max_local_length <= MAX_LOCAL_RESET;
         cfg_ff.max_label_length <= MAX_LABEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            CSR_MAX_TOTAL: cfg_ff.max_total_length <= csr_data;
            CSR_MIN_TOTAL: cfg_ff.min_total_length <= csr_data;
            CSR_MAX_LOCAL: cfg_ff.max_local_length <= csr_data[LABEL_W-1:0];
            CSR_MAX_LABEL: cfg_ff.max_label_length <= csr_data[LABEL_W-1:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   // a non-final byte never needs the result slot
   assign advance   = in_vld_ff && (!in_fin_ff || !rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_char_byte;
         in_fin_ff  <= req_is_final;
      end
   end

   eav_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .char_byte  (in_byte_ff),
      .is_final   (in_fin_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && in_fin_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_fin_ff) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_address_ok     = rsp_ff.address_ok;
   assign rsp_split_position = rsp_ff.split_position;

   `EAV_ASSERT_NOW(a_fail_pos_zero, rsp_valid && !rsp_address_ok, rsp_split_position == 8'd0)
   `EAV_ASSERT_NOW(a_ok_pos_set, rsp_valid && rsp_address_ok, rsp_split_position != 8'd0)
   `EAV_ASSERT_NOW(a_domain_has_at, state_ff.phase == PH_LABEL_START || state_ff.phase == PH_LABEL, state_ff.at_index != 8'd0)
   `EAV_ASSERT_NEXT(a_final_clears, advance && in_fin_ff, state_ff.phase == PH_ATOM_START && state_ff.total_count == 8'd0)

endmodule

`default_nettype wire

>>> tb/email_address_validator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Email address validator core: self-checking testbench
// Streams addresses one byte per item, predicts each verdict from its own
// parser copy and compares every verdict field by field, over several
// register settings, idle/stall mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------

module email_address_validator_core_test;

   import eav_pkg::*;

   localparam logic [7:0] LOCAL_SYMBOLS [18] = '{"!", "#", "$", "%", "&", "*", "+", "/",
      "=", "?", "^", "_", 8'h60, "{", "|", "}", "~", "-"};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = '0;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_address_ok;
   logic [7:0] rsp_split_position;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   // parser copy and register copy
   eav_cfg_type        limits = '{MAX_TOTAL_RESET, MIN_TOTAL_RESET, MAX_LOCAL_RESET,
                                  MAX_LABEL_RESET};
   eav_phase_type      phase = PH_ATOM_START;
   logic [7:0]         total_cnt = '0;
   logic [7:0]         local_cnt = '0;
   logic [6:0]         label_cnt = '0;
   logic [7:0]         at_pos = '0;
   eav_result_type     verdict_q [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_len = 0;
   int unsigned hold_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned verdicts_checked = 0;
   int unsigned valid_verdicts = 0;
   int unsigned settings_used = 1;
   int unsigned errors = 0;

   email_address_validator_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_byte      (req_char_byte),
      .req_is_final       (req_is_final),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_address_ok     (rsp_address_ok),
      .rsp_split_position (rsp_split_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic lower_alnum(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
   endfunction

   function automatic logic local_symbol(input logic [7:0] c);
      foreach (LOCAL_SYMBOLS[i])
         if (c == LOCAL_SYMBOLS[i]) return 1'b1;
      return lower_alnum(c);
   endfunction

   function automatic logic [7:0] pick_alnum();
      int k;
      k = $urandom_range(35);
      return (k < 26) ? 8'("a" + k) : 8'("0" + k - 26);
   endfunction

   function automatic logic [7:0] pick_local();
      if ($urandom_range(3) == 0) return LOCAL_SYMBOLS[$urandom_range(17)];
      return pick_alnum();
   endfunction

   // Advance the parser copy by one byte; on a final byte queue the verdict.
   function automatic void track_byte(input logic [7:0] c, input logic fin);
      eav_result_type verdict;
      logic ok;
      if (total_cnt != BYTE_MAX) total_cnt++;
      case (phase)
         PH_ATOM_START: begin
            if (local_symbol(c)) begin
               if (local_cnt != BYTE_MAX) local_cnt++;
               phase = PH_ATOM;
            end else begin
               phase = PH_FAILED;
            end
         end
         PH_ATOM: begin
            if (local_symbol(c) || c == CHAR_DOT) begin
               if (local_cnt != BYTE_MAX) local_cnt++;
               if (c == CHAR_DOT) phase = PH_ATOM_START;
            end else if (c == CHAR_AT && local_cnt <= limits.max_local_length) begin
               at_pos = local_cnt;
               label_cnt = '0;
               phase = PH_LABEL_START;
            end else begin
               phase = PH_FAILED;
            end
         end
         PH_LABEL_START: begin
            if (lower_alnum(c)) begin
               label_cnt = 7'd1;
               phase = PH_LABEL;
            end else begin
               phase = PH_FAILED;
            end
         end
         PH_LABEL: begin
            if (lower_alnum(c)) begin
               if (label_cnt != LABEL_MAX) label_cnt++;
            end else if ((c == CHAR_DASH || c == CHAR_DOT) &&
                         label_cnt <= limits.max_label_length) begin
               label_cnt = '0;
               phase = PH_LABEL_START;
            end else begin
               phase = PH_FAILED;
            end
         end
         default: phase = PH_FAILED;
      endcase
      if (!fin) return;
      ok = phase == PH_LABEL && label_cnt >= 7'd1 && label_cnt <= limits.max_label_length &&
           total_cnt >= limits.min_total_length && total_cnt <= limits.max_total_length &&
           at_pos != '0;
      verdict.address_ok = ok;
      verdict.split_position = ok ? at_pos : '0;
      verdict_q.push_back(verdict);
      phase = PH_ATOM_START;
      total_cnt = '0;
      local_cnt = '0;
      label_cnt = '0;
      at_pos = '0;
   endfunction

   function automatic void check_verdict();
      eav_result_type want;
      if (verdict_q.size() == 0) begin
         $display("%0t: verdict with none expected: ok=%0b pos=%0d", $time,
                  rsp_address_ok, rsp_split_position);
         errors++;
         return;
      end
      want = verdict_q.pop_front();
      verdicts_checked++;
      if (want.address_ok) valid_verdicts++;
      if (rsp_address_ok !== want.address_ok) begin
         $display("%0t: address_ok expected %0b actual %0b", $time, want.address_ok,
                  rsp_address_ok);
         errors++;
      end
      if (rsp_split_position !== want.split_position) begin
         $display("%0t: split_position expected %0d actual %0d", $time,
                  want.split_position, rsp_split_position);
         errors++;
      end
   endfunction

   // Result side: check taken verdicts, then stall at random or for a hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_verdict();
      if (hold_count < hold_len) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_is_final <= fin;
      do @(posedge clock); while (req_stall);
      track_byte(c, fin);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Mostly well-formed addresses with random content, some cut short or
   // corrupted, and a little pure noise.
   task automatic send_random_address(input int atom_max, input int label_max);
      logic [7:0] text [$];
      int kind, n, pos;
      kind = $urandom_range(99);
      if (kind >= 95) begin
         n = $urandom_range(1, 8);
         repeat (n) text.push_back(8'($urandom_range(255)));
      end else begin
         n = $urandom_range(1, 3);
         for (int a = 0; a < n; a++) begin
            if (a != 0) text.push_back(CHAR_DOT);
            repeat ($urandom_range(1, atom_max)) text.push_back(pick_local());
         end
         text.push_back(CHAR_AT);
         n = $urandom_range(1, 3);
         for (int l = 0; l < n; l++) begin
            if (l != 0) text.push_back($urandom_range(1) ? CHAR_DOT : CHAR_DASH);
            repeat ($urandom_range(1, label_max)) text.push_back(pick_alnum());
         end
         if (kind >= 85) begin
            n = $urandom_range(1, text.size());
            while (text.size() > n) void'(text.pop_back());
         end else if (kind >= 70) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(3))
               0: text[pos] = CHAR_AT;
               1: text[pos] = CHAR_DOT;
               2: text[pos] = CHAR_DASH;
               default: text[pos] = 8'($urandom_range(255));
            endcase
         end
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Drop valid and wait until every verdict is in and the pipe is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input eav_csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_TOTAL: limits.max_total_length = val;
         CSR_MIN_TOTAL: limits.min_total_length = val;
         CSR_MAX_LOCAL: limits.max_local_length = val[6:0];
         default:       limits.max_label_length = val[6:0];
      endcase
   endtask

   task automatic set_limits(input logic [7:0] max_total, input logic [7:0] min_total,
                             input logic [7:0] max_local, input logic [7:0] max_label);
      drain();
      write_reg(CSR_MAX_TOTAL, max_total);
      write_reg(CSR_MIN_TOTAL, min_total);
      write_reg(CSR_MAX_LOCAL, max_local);
      write_reg(CSR_MAX_LABEL, max_label);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic test_directed();
      send_text("a@b");
      send_text("x");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("a.@b");
      send_text("a@");
      send_text("a@b-");
      send_text("!~@0.z");
   endtask

   task automatic test_register_extremes();
      set_limits(MAX_TOTAL_RESET, MIN_TOTAL_RESET, 8'd0, MAX_LABEL_RESET);
      repeat (5) send_random_address(4, 4);
      // bit 7 is dropped by the 7-bit label register
      set_limits(MAX_TOTAL_RESET, MIN_TOTAL_RESET, MAX_LOCAL_RESET, 8'h80);
      repeat (5) send_random_address(4, 4);
      set_limits(8'd0, 8'd0, MAX_LOCAL_RESET, MAX_LABEL_RESET);
      repeat (5) send_random_address(4, 4);
      set_limits(8'd255, 8'd255, 8'hFF, 8'hFF);
      repeat (2) send_random_address(50, 140);
      set_limits(8'd255, 8'd1, 8'd1, 8'd1);
      repeat (10) send_random_address(2, 2);
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               set_limits(MAX_TOTAL_RESET, MIN_TOTAL_RESET, MAX_LOCAL_RESET,
                          MAX_LABEL_RESET);
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               set_limits(8'd20, 8'd5, 8'd4, 8'd3);
               send_idle_pct = 48;
               recv_stall_pct = 0;
            end
            2: begin
               set_limits(8'($urandom_range(10, 255)), 8'($urandom_range(0, 10)),
                          8'($urandom_range(1, 12)), 8'($urandom_range(1, 10)));
               send_idle_pct = 0;
               recv_stall_pct = 48;
            end
            default: begin
               set_limits(MAX_TOTAL_RESET, MIN_TOTAL_RESET, MAX_LOCAL_RESET,
                          MAX_LABEL_RESET);
               send_idle_pct = 25;
               recv_stall_pct = 25;
            end
         endcase
         start = bytes_sent;
         while (bytes_sent - start < 100) begin
            if ($urandom_range(99) < 3) send_random_address(40, 80);
            else send_random_address(6, 6);
         end
      end
   endtask

   // Hold the result side off while bytes keep coming, so the input backs up.
   task automatic test_result_hold_off();
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len <= hold_len + 400;
      repeat (15) send_random_address(3, 3);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random_traffic();
      test_result_hold_off();
      drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d bytes and %0d verdicts (%0d valid) over %0d register settings,",
               bytes_sent, verdicts_checked, valid_verdicts, settings_used);
      $display("with idle and stall mixes, saturating lengths and a long result hold-off.");
      if (errors == 0) begin
         $display("PASS email_address_validator_core");
      end else begin
         $display("FAIL email_address_validator_core");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timeout after %0t", $time);
      $display("FAIL email_address_validator_core");
      $finish;
   end

endmodule

>>> email_address_validator_core.f
+incdir+rtl
rtl/eav_pkg.sv
rtl/eav_step.sv
rtl/email_address_validator_core.sv
tb/email_address_validator_core_test.sv
